// ===== hw/rtl/vim_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the voxel index map.
package vim_pkg;

    localparam int AXIS_MAX_DEF    = 16;
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int SIZE_W   = 5;
    localparam int COORD_W  = 8;
    localparam int OUT_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_OUT_GRID  = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SIZE = 2'd2;

    // Requests from the item pipeline to the slot table.
    typedef struct packed {
        logic wr;
        logic rd;
        logic clear;
    } t_tbl_ctrl;

endpackage

// ===== hw/rtl/vim_slot_table.sv =====
`timescale 1ns / 1ps
// Slot table memory with valid flag per entry and a clearing sweep.
module vim_slot_table
    import vim_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tbl_ctrl             i_ctrl,
    input  logic [AW-1:0]         i_addr,
    input  logic [COUNT_BITS-1:0] i_wr_index,
    output logic                  o_rd_valid,
    output logic [COUNT_BITS-1:0] o_rd_index,
    output logic                  o_busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    logic [COUNT_BITS:0] mem [TABLE_DEPTH];

    logic                  r_busy;
    logic [AW-1:0]         r_sweep_addr;
    logic [COUNT_BITS:0]   r_rd_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_sweep_addr <= '0;
        end else if (i_ctrl.clear) begin
            r_busy       <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_busy) begin
            if (r_sweep_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
            r_sweep_addr <= r_sweep_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_sweep_addr] <= '0;
        end else if (i_ctrl.wr) begin
            mem[i_addr] <= {1'b1, i_wr_index};
        end
        if (i_ctrl.rd) begin
            r_rd_word <= mem[i_addr];
        end
    end

    assign o_rd_valid = r_rd_word[COUNT_BITS];
    assign o_rd_index = r_rd_word[COUNT_BITS-1:0];
    assign o_busy     = r_busy;

endmodule

// ===== hw/rtl/voxel_index_map_unit.sv =====
`timescale 1ns / 1ps
// Voxel index map: top level with grid check, slot pipeline and result register.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | i_in_valid/o_in_stall | func, x_coord, y_coord, z_coord
//  out     | output    | o_out_valid/i_out_stall | status, found_index, entry_total
//  cfg     | input     | i_cfg_valid/o_cfg_ready | cfg_index, cfg_data
//
// Insert and lookup: one beat per cycle unless stalled, via stage A and stage B.
// The slot table has one port; an insert writes it and a lookup reads it.
// Clear: input stalls while the table is swept.
// After reset the same sweep runs before input opens.
// An output stall holds the result register and backs up into the input.
module voxel_index_map_unit
    import vim_pkg::*;
#(
    parameter int AXIS_MAX    = AXIS_MAX_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_func,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic signed [COORD_W-1:0] i_z_coord,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [OUT_W-1:0]      o_found_index,
    output logic [OUT_W-1:0]      o_entry_total,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_W-1:0]     i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [SIZE_W-1:0]     r_x_size, r_y_size, r_z_size;
    logic [2*SIZE_W-1:0]   r_plane;
    logic [COUNT_BITS-1:0] r_count;

    logic                  r_a_vld;
    t_func                 r_a_func;
    logic [COORD_W-1:0]    r_a_x, r_a_y, r_a_z;

    logic                  r_b_vld;
    logic                  r_b_lookup;
    logic                  r_b_in_table;
    t_status               r_b_status;
    logic [OUT_W-1:0]      r_b_found;
    logic [OUT_W-1:0]      r_b_total;

    logic [SIZE_W-1:0]     nx, ny, nz;
    logic                  in_grid;
    logic [OUT_W-1:0]      flat;
    logic                  in_table;
    logic                  full;
    logic                  a_adv;
    logic                  ins_ok;
    t_tbl_ctrl             tbl_ctrl;
    logic                  tbl_rd_valid;
    logic [COUNT_BITS-1:0] tbl_rd_index;
    logic                  tbl_busy;

    t_status               n_status;
    logic [OUT_W-1:0]      n_found;
    logic [COUNT_BITS-1:0] n_count;

    assign nx = (32'(r_x_size) > AXIS_MAX) ? SIZE_W'(AXIS_MAX) : r_x_size;
    assign ny = (32'(r_y_size) > AXIS_MAX) ? SIZE_W'(AXIS_MAX) : r_y_size;
    assign nz = (32'(r_z_size) > AXIS_MAX) ? SIZE_W'(AXIS_MAX) : r_z_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= SIZE_RESET;
            r_y_size <= SIZE_RESET;
            r_z_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_X_SIZE: r_x_size <= i_cfg_data;
                CFG_Y_SIZE: r_y_size <= i_cfg_data;
                CFG_Z_SIZE: r_z_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane <= nx * ny;
    end

    // grid check and flattening
    assign in_grid = !r_a_x[COORD_W-1] && !r_a_y[COORD_W-1] && !r_a_z[COORD_W-1]
                     && (r_a_x[COORD_W-2:0] < (COORD_W-1)'(nx))
                     && (r_a_y[COORD_W-2:0] < (COORD_W-1)'(ny))
                     && (r_a_z[COORD_W-2:0] < (COORD_W-1)'(nz));
    assign flat = OUT_W'(r_a_x[SIZE_W-1:0])
                + OUT_W'(r_a_y[SIZE_W-1:0]) * OUT_W'(nx)
                + OUT_W'(r_a_z[SIZE_W-1:0]) * OUT_W'(r_plane);
    assign in_table = in_grid && (32'(flat) < TABLE_DEPTH);
    assign full     = (r_count == '1);

    assign a_adv      = r_a_vld && (!r_b_vld || !i_out_stall);
    assign o_in_stall = tbl_busy || (r_a_vld && (!a_adv || r_a_func == FUNC_CLEAR));
    assign ins_ok     = (r_a_func == FUNC_INSERT) && in_table && !full;

    assign tbl_ctrl.wr    = a_adv && ins_ok;
    assign tbl_ctrl.rd    = a_adv && (r_a_func == FUNC_LOOKUP);
    assign tbl_ctrl.clear = a_adv && (r_a_func == FUNC_CLEAR);

    vim_slot_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (tbl_ctrl),
        .i_addr     (AW'(flat)),
        .i_wr_index (r_count),
        .o_rd_valid (tbl_rd_valid),
        .o_rd_index (tbl_rd_index),
        .o_busy     (tbl_busy)
    );

    always_comb begin
        n_status = ST_OK;
        n_found  = '0;
        n_count  = r_count;
        case (r_a_func)
            FUNC_INSERT: begin
                if (!in_table) begin
                    n_status = ST_OUT_GRID;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_found = OUT_W'(r_count);
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_LOOKUP: n_status = ST_NOT_FOUND;
            FUNC_CLEAR:  n_count  = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_a_vld <= 1'b1;
            end else if (a_adv) begin
                r_a_vld <= 1'b0;
            end
            if (a_adv) begin
                r_b_vld <= 1'b1;
                r_count <= n_count;
            end else if (!i_out_stall) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_a_func <= t_func'(i_func);
            r_a_x    <= i_x_coord;
            r_a_y    <= i_y_coord;
            r_a_z    <= i_z_coord;
        end
        if (a_adv) begin
            r_b_lookup   <= (r_a_func == FUNC_LOOKUP);
            r_b_in_table <= in_table;
            r_b_status   <= n_status;
            r_b_found    <= n_found;
            r_b_total    <= OUT_W'(n_count);
        end
    end

    // lookup result comes from the table's registered read
    always_comb begin
        o_status      = r_b_status;
        o_found_index = r_b_found;
        if (r_b_lookup && r_b_in_table && tbl_rd_valid) begin
            o_status      = ST_OK;
            o_found_index = OUT_W'(tbl_rd_index);
        end
    end

    assign o_out_valid   = r_b_vld;
    assign o_entry_total = r_b_total;

endmodule

// ===== tb/sv/voxel_index_map_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for voxel_index_map_unit: random and directed beats against a predictor.
module voxel_index_map_unit_tb;
    import vim_pkg::*;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          SETTLE      = 10;
    localparam int          PHASE_ITEMS = 100;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_FULL = '1;

    typedef struct {
        t_func              func;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } voxel_cmd_t;

    typedef struct {
        t_status            status;
        logic [OUT_W-1:0]   found_index;
        logic [OUT_W-1:0]   entry_total;
    } voxel_res_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [1:0]                 i_func = FUNC_NOP;
    logic signed [COORD_W-1:0]  i_x_coord = '0;
    logic signed [COORD_W-1:0]  i_y_coord = '0;
    logic signed [COORD_W-1:0]  i_z_coord = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [1:0]                 o_status;
    logic [OUT_W-1:0]           o_found_index;
    logic [OUT_W-1:0]           o_entry_total;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_X_SIZE;
    logic [SIZE_W-1:0]          i_cfg_data = '0;

    voxel_cmd_t                 pending_cmds[$];
    voxel_res_t                 expected_results[$];
    voxel_cmd_t                 recent_voxels[$];
    voxel_cmd_t                 beat_cmd;

    // predictor state
    logic [SIZE_W-1:0]          grid_size [3] = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
    bit                         slot_used [TABLE_DEPTH_DEF];
    logic [COUNT_BITS_DEF-1:0]  slot_value [TABLE_DEPTH_DEF];
    logic [COUNT_BITS_DEF-1:0]  entry_count = '0;

    int unsigned                cycle_cnt = 0;
    int unsigned                fail_cnt = 0;
    int unsigned                results_seen = 0;
    int unsigned                n_insert = 0;
    int unsigned                n_lookup = 0;
    int unsigned                n_clear = 0;
    int unsigned                n_nop = 0;
    int unsigned                n_full = 0;
    int unsigned                n_outside = 0;
    int unsigned                n_grids = 0;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    int                         hold_req = 0;
    int                         hold_seen = 0;
    int                         hold_left = 0;

    voxel_index_map_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_z_coord     (i_z_coord),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_entry_total (o_entry_total),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int axis_span(logic [SIZE_W-1:0] n);
        return (n > AXIS_MAX_DEF) ? AXIS_MAX_DEF : int'(n);
    endfunction

    function automatic voxel_res_t predict_voxel(voxel_cmd_t c);
        voxel_res_t r;
        int nx, ny, nz, xi, yi, zi, flat;
        bit in_grid;
        nx = axis_span(grid_size[CFG_X_SIZE]);
        ny = axis_span(grid_size[CFG_Y_SIZE]);
        nz = axis_span(grid_size[CFG_Z_SIZE]);
        xi = c.x_coord;
        yi = c.y_coord;
        zi = c.z_coord;
        in_grid = xi >= 0 && yi >= 0 && zi >= 0 && xi < nx && yi < ny && zi < nz;
        flat = xi + yi * nx + zi * nx * ny;
        if (in_grid && flat >= TABLE_DEPTH_DEF)
            in_grid = 1'b0;
        r.status = ST_OK;
        r.found_index = '0;
        case (c.func)
            FUNC_INSERT: begin
                n_insert++;
                if (!in_grid) begin
                    r.status = ST_OUT_GRID;
                    n_outside++;
                end else if (entry_count == COUNT_FULL) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    slot_used[flat] = 1'b1;
                    slot_value[flat] = entry_count;
                    r.found_index = entry_count;
                    entry_count = entry_count + 1'b1;
                end
            end
            FUNC_LOOKUP: begin
                n_lookup++;
                if (in_grid && slot_used[flat])
                    r.found_index = slot_value[flat];
                else
                    r.status = ST_NOT_FOUND;
            end
            FUNC_CLEAR: begin
                n_clear++;
                slot_used = '{default: 1'b0};
                entry_count = '0;
            end
            default: begin
                n_nop++;
            end
        endcase
        r.entry_total = entry_count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // input side: one beat in flight on the pins, next taken from the queue
    always @(posedge i_clk) begin : drive_proc
        voxel_cmd_t nxt;
        bit take;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take = !i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_results = {expected_results, predict_voxel(beat_cmd)};
                take = 1'b1;
            end
            if (take) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_cmds.pop_front();
                    beat_cmd = nxt;
                    i_in_valid <= 1'b1;
                    i_func <= nxt.func;
                    i_x_coord <= nxt.x_coord;
                    i_y_coord <= nxt.y_coord;
                    i_z_coord <= nxt.z_coord;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_proc
        voxel_res_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("cycle %0d: unexpected beat status %0d index %0d total %0d",
                             cycle_cnt, o_status, o_found_index, o_entry_total);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_found_index !== want.found_index ||
                    o_entry_total !== want.entry_total) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display({"cycle %0d: mismatch exp/act status %0d/%0d",
                                  " index %0d/%0d total %0d/%0d"},
                                 cycle_cnt, want.status, o_status, want.found_index,
                                 o_found_index, want.entry_total, o_entry_total);
                end
            end
        end
    end

    task automatic push_cmd(t_func f, int x, int y, int z);
        voxel_cmd_t c;
        c.func = f;
        c.x_coord = COORD_W'(x);
        c.y_coord = COORD_W'(y);
        c.z_coord = COORD_W'(z);
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        grid_size[idx] = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(int nx, int ny, int nz);
        wait_idle();
        repeat (SETTLE) @(negedge i_clk);
        write_size(CFG_X_SIZE, SIZE_W'(nx));
        write_size(CFG_Y_SIZE, SIZE_W'(ny));
        write_size(CFG_Z_SIZE, SIZE_W'(nz));
        @(negedge i_clk);
        recent_voxels.delete();
        n_grids++;
    endtask

    function automatic int pick_coord(int n);
        if (n > 0 && $urandom_range(0, 99) < 75)
            return $urandom_range(0, n - 1);
        return $urandom_range(0, 255);
    endfunction

    // each coordinate mostly inside its axis, with coordinates reused from recent inserts so lookups can hit
    task automatic push_random(int count);
        voxel_cmd_t c;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            c.func = t_func'((r < 45) ? FUNC_INSERT : (r < 92) ? FUNC_LOOKUP :
                             (r < 96) ? FUNC_NOP : FUNC_CLEAR);
            if (c.func != FUNC_CLEAR && recent_voxels.size() != 0 &&
                $urandom_range(0, 99) < 40) begin
                c = '{c.func, recent_voxels[$urandom_range(0, recent_voxels.size() - 1)].x_coord,
                      recent_voxels[$urandom_range(0, recent_voxels.size() - 1)].y_coord,
                      recent_voxels[$urandom_range(0, recent_voxels.size() - 1)].z_coord};
            end else begin
                c.x_coord = COORD_W'(pick_coord(axis_span(grid_size[CFG_X_SIZE])));
                c.y_coord = COORD_W'(pick_coord(axis_span(grid_size[CFG_Y_SIZE])));
                c.z_coord = COORD_W'(pick_coord(axis_span(grid_size[CFG_Z_SIZE])));
            end
            if (c.func == FUNC_INSERT) begin
                recent_voxels = {recent_voxels, c};
                if (recent_voxels.size() > 32)
                    void'(recent_voxels.pop_front());
            end
            pending_cmds = {pending_cmds, c};
        end
    endtask

    task automatic random_phase(int nx, int ny, int nz);
        set_grid(nx, ny, nz);
        push_random(PHASE_ITEMS / 2);
        wait_idle();
        push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 20;
        recv_stall_pct = 72;
        set_grid(5, 3, 2);
        push_cmd(FUNC_INSERT, 0, 0, 0);
        push_cmd(FUNC_INSERT, 4, 2, 1);
        push_cmd(FUNC_LOOKUP, 4, 2, 1);
        push_cmd(FUNC_INSERT, 5, 0, 0);
        push_cmd(FUNC_INSERT, -1, 0, 0);
        push_cmd(FUNC_INSERT, 127, 127, 127);
        push_cmd(FUNC_INSERT, -128, -128, -128);
        push_cmd(FUNC_LOOKUP, 0, 3, 0);
        push_cmd(FUNC_LOOKUP, 1, 1, 1);
        push_cmd(FUNC_INSERT, 0, 0, 0);
        push_cmd(FUNC_LOOKUP, 0, 0, 0);
        push_cmd(FUNC_NOP, 127, -128, 85);
        push_cmd(FUNC_CLEAR, 0, 0, 0);
        push_cmd(FUNC_LOOKUP, 4, 2, 1);
        push_cmd(FUNC_INSERT, 2, 1, 1);
        push_cmd(FUNC_LOOKUP, 2, 1, 1);
        // zero-sized axis: nothing lies in the grid
        set_grid(0, 16, 16);
        push_cmd(FUNC_INSERT, 0, 0, 0);
        push_cmd(FUNC_LOOKUP, 0, 0, 0);
        // sizes above the axis maximum are clamped
        set_grid(31, 17, 16);
        push_cmd(FUNC_INSERT, 15, 15, 15);
        push_cmd(FUNC_INSERT, 16, 0, 0);
        push_cmd(FUNC_LOOKUP, 15, 15, 15);
        push_cmd(FUNC_LOOKUP, -1, -1, -1);

        random_phase(16, 16, 16);
        random_phase(1, 1, 1);
        send_idle_pct = 72;
        recv_stall_pct = 20;
        random_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16));
        random_phase($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(2, 16, 1);
        set_grid($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16));
        hold_req = hold_req + 1;
        push_random(PHASE_ITEMS);

        // re-insert, miss and no-op around a fresh clear
        set_grid(16, 16, 16);
        push_cmd(FUNC_CLEAR, 0, 0, 0);
        push_cmd(FUNC_INSERT, 3, 7, 11);
        push_cmd(FUNC_INSERT, 3, 7, 11);
        push_cmd(FUNC_LOOKUP, 3, 7, 11);
        push_cmd(FUNC_INSERT, -1, 0, 0);
        push_cmd(FUNC_NOP, 0, 0, 0);
        push_cmd(FUNC_CLEAR, 0, 0, 0);
        push_cmd(FUNC_LOOKUP, 3, 7, 11);
        push_cmd(FUNC_INSERT, 3, 7, 11);
        push_cmd(FUNC_LOOKUP, 3, 7, 11);

        wait_idle();
        repeat (SETTLE) @(negedge i_clk);
        fail_cnt += expected_results.size();
        $display("%0d results checked: %0d inserts, %0d lookups, %0d clears, %0d no-ops",
                 results_seen, n_insert, n_lookup, n_clear, n_nop);
        $display("%0d grid settings, %0d out-of-grid inserts, %0d inserts at saturation",
                 n_grids, n_outside, n_full);
        if (fail_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
